FILE: rtl/wcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wcc_pkg
// Shared types and codes of the wall clock with commands: input and result
// words, the internal command word and the character constants.
// ----------------------------------------------------------------------------
package wcc_pkg;

    // input word kinds
    localparam logic [1:0] KIND_TICK      = 2'd0;
    localparam logic [1:0] KIND_SET       = 2'd1;
    localparam logic [1:0] KIND_RESET     = 2'd2;
    localparam logic [1:0] KIND_TERMINATE = 2'd3;

    // shortest texts that still carry a command
    localparam logic [3:0] MIN_CMD_LEN = 4'd3;
    localparam logic [3:0] MIN_SET_LEN = 4'd12;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_TWO   = 8'h32;
    localparam logic [7:0] CHAR_THREE = 8'h33;
    localparam logic [7:0] CHAR_FIVE  = 8'h35;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic LINE_TIME  = 1'b0;
    localparam logic LINE_BLANK = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] text_length;
        logic [7:0] separator_char;
        logic [7:0] hour_tens_char;
        logic [7:0] hour_units_char;
        logic [7:0] first_colon_char;
        logic [7:0] minute_tens_char;
        logic [7:0] minute_units_char;
        logic [7:0] second_colon_char;
        logic [7:0] second_tens_char;
        logic [7:0] second_units_char;
    } in_item_t;

    typedef struct packed {
        logic       line_kind;
        logic       leading_newline;
        logic [1:0] hour_tens;
        logic [3:0] hour_units;
        logic [2:0] minute_tens;
        logic [3:0] minute_units;
        logic [2:0] second_tens;
        logic [3:0] second_units;
        logic       schedule_tick;
    } out_item_t;

    // time of day held as decimal digits
    typedef struct packed {
        logic [1:0] ht;
        logic [3:0] hu;
        logic [2:0] mt;
        logic [3:0] mu;
        logic [2:0] st;
        logic [3:0] su;
    } tod_t;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_LOAD,
        OP_ZERO,
        OP_STOP,
        OP_BLANK
    } op_t;

    typedef struct packed {
        op_t  op;
        tod_t tod;
    } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/wcc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wcc_front
// Command decoder: checks the text of each word, drops words that carry no
// command and turns the rest into command words for the back end.
// ----------------------------------------------------------------------------
module wcc_front (
    input  wire wcc_pkg::in_item_t item,
    output logic                   keep,
    output wcc_pkg::cmd_t          cmd
);
    import wcc_pkg::*;

    function automatic logic in_range(input logic [7:0] c, input logic [7:0] lo,
                                      input logic [7:0] hi);
        in_range = (c >= lo) && (c <= hi);
    endfunction

    logic hour_ok;
    logic text_ok;

    assign hour_ok = ((item.hour_tens_char == CHAR_ZERO || item.hour_tens_char == CHAR_ONE)
                      && in_range(item.hour_units_char, CHAR_ZERO, CHAR_NINE))
                     || (item.hour_tens_char == CHAR_TWO
                      && in_range(item.hour_units_char, CHAR_ZERO, CHAR_THREE));

    assign text_ok = (item.separator_char == CHAR_SPACE)
                     && (item.first_colon_char == CHAR_COLON)
                     && in_range(item.minute_tens_char, CHAR_ZERO, CHAR_FIVE)
                     && in_range(item.minute_units_char, CHAR_ZERO, CHAR_NINE)
                     && (item.second_colon_char == CHAR_COLON)
                     && in_range(item.second_tens_char, CHAR_ZERO, CHAR_FIVE)
                     && in_range(item.second_units_char, CHAR_ZERO, CHAR_NINE)
                     && hour_ok;

    always_comb begin
        keep        = 1'b1;
        cmd.op      = OP_TICK;
        // digits are only used by a load, where the text is known good
        cmd.tod.ht  = item.hour_tens_char[1:0];
        cmd.tod.hu  = item.hour_units_char[3:0];
        cmd.tod.mt  = item.minute_tens_char[2:0];
        cmd.tod.mu  = item.minute_units_char[3:0];
        cmd.tod.st  = item.second_tens_char[2:0];
        cmd.tod.su  = item.second_units_char[3:0];
        unique case (item.kind)
            KIND_TICK: begin
                cmd.op = OP_TICK;
            end
            KIND_SET: begin
                keep   = (item.text_length >= MIN_SET_LEN);
                cmd.op = text_ok ? OP_LOAD : OP_BLANK;
            end
            KIND_RESET: begin
                keep   = (item.text_length >= MIN_CMD_LEN);
                cmd.op = OP_ZERO;
            end
            KIND_TERMINATE: begin
                keep   = (item.text_length >= MIN_CMD_LEN);
                cmd.op = OP_STOP;
            end
            default: begin
                keep   = 1'b0;
                cmd.op = OP_TICK;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/wcc_cmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wcc_cmd_fifo
// Small register queue of command words between decoder and back end.
// ----------------------------------------------------------------------------
module wcc_cmd_fifo #(
    parameter int DEPTH = 2
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  wire wcc_pkg::cmd_t  push_cmd,
    output logic                full,
    input  wire                 pop,
    output wcc_pkg::cmd_t       pop_cmd,
    output logic                empty
);
    import wcc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("command queue count beyond depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("command queue count did not follow a push");

endmodule
`default_nettype wire

FILE: rtl/wcc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wcc_back
// Clock core: holds the time of day and run flags, executes command words
// and drives the registered result word.
// ----------------------------------------------------------------------------
module wcc_back (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cmd_avail,
    input  wire wcc_pkg::cmd_t    cmd,
    output logic                  cmd_pop,
    output logic                  m_valid,
    input  wire                   m_ready,
    output wcc_pkg::out_item_t    m_data
);
    import wcc_pkg::*;

    tod_t      tod_reg, tod_next, tod_inc;
    logic      running_reg, running_next;
    logic      ignore_reg, ignore_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;
    logic      emit;

    assign cmd_pop = cmd_avail && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // one second later, 23:59:59 rolls over to midnight
    always_comb begin
        tod_inc = tod_reg;
        if (tod_reg.su != 4'd9) begin
            tod_inc.su = tod_reg.su + 4'd1;
        end else begin
            tod_inc.su = '0;
            if (tod_reg.st != 3'd5) begin
                tod_inc.st = tod_reg.st + 3'd1;
            end else begin
                tod_inc.st = '0;
                if (tod_reg.mu != 4'd9) begin
                    tod_inc.mu = tod_reg.mu + 4'd1;
                end else begin
                    tod_inc.mu = '0;
                    if (tod_reg.mt != 3'd5) begin
                        tod_inc.mt = tod_reg.mt + 3'd1;
                    end else begin
                        tod_inc.mt = '0;
                        priority if (tod_reg.ht == 2'd2 && tod_reg.hu == 4'd3) begin
                            tod_inc.ht = '0;
                            tod_inc.hu = '0;
                        end else if (tod_reg.hu == 4'd9) begin
                            tod_inc.ht = tod_reg.ht + 2'd1;
                            tod_inc.hu = '0;
                        end else begin
                            tod_inc.hu = tod_reg.hu + 4'd1;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        tod_next     = tod_reg;
        running_next = running_reg;
        ignore_next  = ignore_reg;
        emit         = 1'b0;
        out_next     = '0;
        out_next.line_kind = LINE_BLANK;
        if (cmd_pop) begin
            unique case (cmd.op)
                OP_TICK: begin
                    if (running_reg && !ignore_reg) begin
                        tod_next = tod_inc;
                        emit     = 1'b1;
                        out_next.line_kind     = LINE_TIME;
                        out_next.schedule_tick = 1'b1;
                    end else begin
                        ignore_next = 1'b0;
                    end
                end
                OP_LOAD, OP_ZERO: begin
                    tod_next = (cmd.op == OP_LOAD) ? cmd.tod : '0;
                    emit     = 1'b1;
                    out_next.line_kind       = LINE_TIME;
                    out_next.leading_newline = 1'b1;
                    out_next.schedule_tick   = 1'b1;
                    // a restart while running leaves one stale tick in flight
                    if (!running_reg) begin
                        running_next = 1'b1;
                    end else begin
                        ignore_next = 1'b1;
                    end
                end
                OP_STOP: begin
                    emit = 1'b1;
                    if (running_reg) begin
                        running_next = 1'b0;
                        ignore_next  = 1'b1;
                    end
                end
                OP_BLANK: begin
                    emit = 1'b1;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
            if (out_next.line_kind == LINE_TIME) begin
                out_next.hour_tens    = tod_next.ht;
                out_next.hour_units   = tod_next.hu;
                out_next.minute_tens  = tod_next.mt;
                out_next.minute_units = tod_next.mu;
                out_next.second_tens  = tod_next.st;
                out_next.second_units = tod_next.su;
            end
        end
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tod_reg       <= '0;
            running_reg   <= 1'b0;
            ignore_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            tod_reg       <= tod_next;
            running_reg   <= running_next;
            ignore_reg    <= ignore_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= out_next;
        end
    end

    a_blank_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.line_kind == LINE_BLANK) |->
        (out_reg.hour_tens == '0 && out_reg.hour_units == '0 && out_reg.minute_tens == '0
         && out_reg.minute_units == '0 && out_reg.second_tens == '0
         && out_reg.second_units == '0 && !out_reg.leading_newline
         && !out_reg.schedule_tick))
        else $error("blank line carries nonzero fields");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.line_kind == LINE_TIME) |->
        ((out_reg.hour_tens < 2'd2 || (out_reg.hour_tens == 2'd2 && out_reg.hour_units <= 4'd3))
         && out_reg.hour_units <= 4'd9 && out_reg.minute_tens <= 3'd5
         && out_reg.minute_units <= 4'd9 && out_reg.second_tens <= 3'd5
         && out_reg.second_units <= 4'd9 && out_reg.schedule_tick))
        else $error("time line out of range");

    a_stop_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_pop && cmd.op == OP_STOP) |=> (!running_reg && m_valid))
        else $error("terminate did not stop the clock");

    a_idle_tick_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_pop && cmd.op == OP_TICK && !running_reg) |=> (!m_valid && !ignore_reg))
        else $error("tick on a stopped clock gave a result");

endmodule
`default_nettype wire

FILE: rtl/wall_clock_with_commands.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wall_clock_with_commands
// 24-hour wall clock driven by tick, set, reset and terminate words.
// ----------------------------------------------------------------------------
// Takes one command word per cycle while the queue has room and gives at most
// one result word per command. A decoder checks the set text and drops words
// without a command, a queue of CMD_DEPTH words decouples it from the clock
// core; the core updates the time digits and the result register together.
// An accepted command waits in the queue until the core takes it; with the
// default queue of two words the block sustains one word per cycle as long as
// m_ready keeps up, and a stalled result holds back only the core while the
// queue takes up to CMD_DEPTH further words.
module wall_clock_with_commands #(
    parameter int CMD_DEPTH = 2
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire wcc_pkg::in_item_t s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output wcc_pkg::out_item_t    m_data
);
    import wcc_pkg::*;

    logic keep;
    cmd_t dec_cmd;
    cmd_t q_cmd;
    logic q_full, q_empty, q_pop;

    assign s_ready = !q_full;

    wcc_front u_front (
        .item (s_data),
        .keep (keep),
        .cmd  (dec_cmd)
    );

    wcc_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_valid && s_ready && keep),
        .push_cmd (dec_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_cmd),
        .empty    (q_empty)
    );

    wcc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_avail (!q_empty),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wall clock with commands.
// ----------------------------------------------------------------------------
// A directed list covers the short and ignored commands, the set text checks
// at their edges, start while running, terminate and the midnight wrap. A
// random part then sends mostly well-formed set, reset, terminate and tick
// words with some broken texts and raw noise. A clocked driver feeds the
// words from a queue; a clocked monitor predicts each accepted word and checks
// every result field against the oldest expected line. The sender and the
// receiver stall at random in three phases, the last one without stalls.
// ----------------------------------------------------------------------------
module tb;
    import wcc_pkg::*;

    localparam int RANDOM_WORDS   = 1700;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_PRINTED    = 40;
    localparam int DAY_LAST       = 86399;
    localparam int IN_W           = $bits(in_item_t);

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    wall_clock_with_commands DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    in_item_t  pending_cmds[$];
    out_item_t due_lines[$];

    // predicted clock state
    int tod_secs      = 0;
    bit tod_running   = 1'b0;
    bit tod_skip_tick = 1'b0;

    int total_words    = 0;
    int words_sent     = 0;
    int words_accepted = 0;
    int lines_checked  = 0;
    int time_lines     = 0;
    int blank_lines    = 0;
    int midnight_wraps = 0;
    int mismatches     = 0;
    int stall_cycles   = 0;
    int sender_idle;
    int receiver_idle;

    always @* begin
        if (words_sent < total_words / 3) begin
            sender_idle   = 35;
            receiver_idle = 50;
        end else if (words_sent < 2 * total_words / 3) begin
            sender_idle   = 50;
            receiver_idle = 35;
        end else begin
            sender_idle   = 0;
            receiver_idle = 0;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic bit char_in(input logic [7:0] c, input logic [7:0] lo,
                                   input logic [7:0] hi);
        return c >= lo && c <= hi;
    endfunction

    function automatic bit time_text_ok(input in_item_t cmd);
        bit hour_ok;
        hour_ok = ((cmd.hour_tens_char == CHAR_ZERO || cmd.hour_tens_char == CHAR_ONE) &&
                   char_in(cmd.hour_units_char, CHAR_ZERO, CHAR_NINE)) ||
                  (cmd.hour_tens_char == CHAR_TWO &&
                   char_in(cmd.hour_units_char, CHAR_ZERO, CHAR_THREE));
        return cmd.separator_char == CHAR_SPACE && cmd.first_colon_char == CHAR_COLON &&
               char_in(cmd.minute_tens_char, CHAR_ZERO, CHAR_FIVE) &&
               char_in(cmd.minute_units_char, CHAR_ZERO, CHAR_NINE) &&
               cmd.second_colon_char == CHAR_COLON &&
               char_in(cmd.second_tens_char, CHAR_ZERO, CHAR_FIVE) &&
               char_in(cmd.second_units_char, CHAR_ZERO, CHAR_NINE) &&
               hour_ok;
    endfunction

    function automatic out_item_t time_line(input bit leading);
        out_item_t line;
        int h, m, s;
        h = tod_secs / 3600;
        m = (tod_secs % 3600) / 60;
        s = tod_secs % 60;
        line.line_kind       = LINE_TIME;
        line.leading_newline = leading;
        line.hour_tens       = 2'(h / 10);
        line.hour_units      = 4'(h % 10);
        line.minute_tens     = 3'(m / 10);
        line.minute_units    = 4'(m % 10);
        line.second_tens     = 3'(s / 10);
        line.second_units    = 4'(s % 10);
        line.schedule_tick   = 1'b1;
        return line;
    endfunction

    // advances the predicted clock by one command word; returns 1 when a line is due
    function automatic bit clock_step(input in_item_t cmd, output out_item_t line);
        line = '0;
        if (cmd.kind == KIND_TICK) begin
            if (tod_running && !tod_skip_tick) begin
                if (tod_secs < DAY_LAST) begin
                    tod_secs++;
                end else begin
                    tod_secs = 0;
                    midnight_wraps++;
                end
                line = time_line(1'b0);
                return 1'b1;
            end
            tod_skip_tick = 1'b0;
            return 1'b0;
        end
        if (cmd.text_length < MIN_CMD_LEN)
            return 1'b0;
        if (cmd.kind == KIND_TERMINATE) begin
            if (tod_running) begin
                tod_running   = 1'b0;
                tod_skip_tick = 1'b1;
            end
            line.line_kind = LINE_BLANK;
            return 1'b1;
        end
        if (cmd.kind == KIND_SET) begin
            if (cmd.text_length < MIN_SET_LEN)
                return 1'b0;
            if (!time_text_ok(cmd)) begin
                line.line_kind = LINE_BLANK;
                return 1'b1;
            end
            tod_secs = (int'(cmd.hour_tens_char - CHAR_ZERO) * 10 +
                        int'(cmd.hour_units_char - CHAR_ZERO)) * 3600 +
                       (int'(cmd.minute_tens_char - CHAR_ZERO) * 10 +
                        int'(cmd.minute_units_char - CHAR_ZERO)) * 60 +
                       int'(cmd.second_tens_char - CHAR_ZERO) * 10 +
                       int'(cmd.second_units_char - CHAR_ZERO);
        end else begin
            tod_secs = 0;
        end
        line = time_line(1'b1);
        if (!tod_running)
            tod_running = 1'b1;
        else
            tod_skip_tick = 1'b1;
        return 1'b1;
    endfunction

    function automatic in_item_t noise_word();
        in_item_t w;
        w = IN_W'({$urandom, $urandom, $urandom});
        return w;
    endfunction

    function automatic in_item_t cmd_word(input logic [1:0] kind, input int len);
        in_item_t w;
        w = noise_word();
        w.kind        = kind;
        w.text_length = 4'(len);
        return w;
    endfunction

    function automatic in_item_t set_word(input int len, input int h, input int m,
                                          input int s);
        in_item_t w;
        w = cmd_word(KIND_SET, len);
        w.separator_char    = CHAR_SPACE;
        w.hour_tens_char    = CHAR_ZERO + 8'(h / 10);
        w.hour_units_char   = CHAR_ZERO + 8'(h % 10);
        w.first_colon_char  = CHAR_COLON;
        w.minute_tens_char  = CHAR_ZERO + 8'(m / 10);
        w.minute_units_char = CHAR_ZERO + 8'(m % 10);
        w.second_colon_char = CHAR_COLON;
        w.second_tens_char  = CHAR_ZERO + 8'(s / 10);
        w.second_units_char = CHAR_ZERO + 8'(s % 10);
        return w;
    endfunction

    function automatic int cmd_len();
        if ($urandom_range(7) == 0)
            return $urandom_range(15);
        return $urandom_range(15, 3);
    endfunction

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle) begin
                s_data     <= pending_cmds.pop_front();
                s_valid    <= 1'b1;
                words_sent <= words_sent + 1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= receiver_idle);
    end

    // monitor, predictor and watchdog
    always @(posedge aclk) begin
        out_item_t want;
        out_item_t line;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (due_lines.size() == 0) begin
                    report_mismatch("result word with no expected line");
                end else begin
                    want = due_lines.pop_front();
                    check_field("line_kind", int'(m_data.line_kind), int'(want.line_kind));
                    check_field("leading_newline", int'(m_data.leading_newline),
                                int'(want.leading_newline));
                    check_field("hour_tens", int'(m_data.hour_tens), int'(want.hour_tens));
                    check_field("hour_units", int'(m_data.hour_units),
                                int'(want.hour_units));
                    check_field("minute_tens", int'(m_data.minute_tens),
                                int'(want.minute_tens));
                    check_field("minute_units", int'(m_data.minute_units),
                                int'(want.minute_units));
                    check_field("second_tens", int'(m_data.second_tens),
                                int'(want.second_tens));
                    check_field("second_units", int'(m_data.second_units),
                                int'(want.second_units));
                    check_field("schedule_tick", int'(m_data.schedule_tick),
                                int'(want.schedule_tick));
                    lines_checked++;
                    if (want.line_kind == LINE_BLANK)
                        blank_lines++;
                    else
                        time_lines++;
                end
            end
            if (s_valid && s_ready) begin
                words_accepted++;
                if (clock_step(s_data, line))
                    due_lines.push_back(line);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", stall_cycles);
                $display("FAIL");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        in_item_t w;
        int pick, h, m, s;

        // directed part
        pending_cmds.push_back(cmd_word(KIND_TICK, 0));          // stopped clock
        pending_cmds.push_back(set_word(11, 12, 0, 0));          // set too short
        pending_cmds.push_back(set_word(2, 12, 0, 0));           // no command letter
        pending_cmds.push_back(cmd_word(KIND_RESET, 2));
        pending_cmds.push_back(cmd_word(KIND_TERMINATE, 2));
        pending_cmds.push_back(set_word(12, 23, 59, 59));        // start from stopped
        pending_cmds.push_back(cmd_word(KIND_TICK, 15));         // midnight wrap
        pending_cmds.push_back(set_word(15, 0, 0, 0));           // start while running
        pending_cmds.push_back(cmd_word(KIND_TICK, 5));          // stale tick
        pending_cmds.push_back(cmd_word(KIND_TICK, 5));
        pending_cmds.push_back(set_word(12, 24, 0, 0));          // hour out of range
        pending_cmds.push_back(set_word(12, 19, 59, 59));
        w = set_word(12, 20, 0, 0);
        w.hour_units_char = CHAR_THREE + 8'd1;
        pending_cmds.push_back(w);
        w = set_word(13, 10, 10, 10);
        w.separator_char = CHAR_COLON;
        pending_cmds.push_back(w);
        w = set_word(13, 10, 10, 10);
        w.first_colon_char = CHAR_SPACE;
        pending_cmds.push_back(w);
        w = set_word(14, 10, 10, 10);
        w.minute_tens_char = CHAR_FIVE + 8'd1;
        pending_cmds.push_back(w);
        w = set_word(14, 10, 10, 10);
        w.second_tens_char = CHAR_FIVE + 8'd1;
        w.second_units_char = CHAR_NINE + 8'd1;
        pending_cmds.push_back(w);
        w = set_word(12, 10, 10, 10);
        w.hour_tens_char = CHAR_ZERO - 8'd1;
        pending_cmds.push_back(w);
        pending_cmds.push_back(cmd_word(KIND_RESET, 3));
        pending_cmds.push_back(cmd_word(KIND_TERMINATE, 3));
        pending_cmds.push_back(cmd_word(KIND_TERMINATE, 15));    // already stopped
        pending_cmds.push_back(cmd_word(KIND_TICK, 0));
        pending_cmds.push_back(cmd_word(KIND_TICK, 0));
        w = '1;
        w.kind = KIND_SET;
        pending_cmds.push_back(w);
        w = '0;
        w.kind = KIND_SET;
        w.text_length = 4'd12;
        pending_cmds.push_back(w);

        // random part: mostly well-formed commands, some broken texts and noise
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                w = cmd_word(KIND_TICK, $urandom_range(15));
            end else if (pick < 72) begin
                if ($urandom_range(3) == 0) begin
                    h = 23;
                    m = 59;
                    s = $urandom_range(59, 50);
                end else begin
                    h = $urandom_range(23);
                    m = $urandom_range(59);
                    s = $urandom_range(59);
                end
                if ($urandom_range(9) == 0)
                    w = set_word($urandom_range(15), h, m, s);
                else
                    w = set_word($urandom_range(15, 12), h, m, s);
                // break one character of the text now and then
                if ($urandom_range(3) == 0)
                    w[8 * $urandom_range(8) +: 8] = 8'($urandom);
            end else if (pick < 80) begin
                w = cmd_word(KIND_RESET, cmd_len());
            end else if (pick < 88) begin
                w = cmd_word(KIND_TERMINATE, cmd_len());
            end else begin
                w = noise_word();
            end
            pending_cmds.push_back(w);
        end
        total_words = pending_cmds.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_cmds.size() > 0 || s_valid)
            @(posedge aclk);
        while (due_lines.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("words accepted %0d, result lines checked %0d (%0d time, %0d blank)",
                 words_accepted, lines_checked, time_lines, blank_lines);
        $display("midnight wraps seen %0d, mismatches %0d", midnight_wraps, mismatches);
        if (mismatches == 0 && due_lines.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: wall_clock_with_commands.f
rtl/wcc_pkg.sv
rtl/wcc_front.sv
rtl/wcc_cmd_fifo.sv
rtl/wcc_back.sv
rtl/wall_clock_with_commands.sv
tb/tb.sv
